// ===== rtl/assert_macros.svh =====
// assertion macros shared by the level meter rtl
// depends on nothing; synthesis builds define SYNTHESIS to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/wprm_pkg.sv =====
// constants and item types of the windowed peak and rms level meter
// used by wprm_arith and windowed_peak_rms_meter; depends on nothing
package wprm_pkg;

    // window depth must be a power of two, the mean of squares is a shift
    localparam int CHANNELS     = 5;
    localparam int WINDOW_DEPTH = 1024;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int LEVEL_W  = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;
    localparam logic [LEVEL_W-1:0]  MAG_MAX      = 16'h8000;

    // one extra bit so that a count of eight channels still compares
    localparam int CH_CNT_W    = CHAN_W + 1;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W       = $clog2(WINDOW_DEPTH);
    localparam int WIN_ENTRIES = CHANNELS * WINDOW_DEPTH;
    localparam int ADDR_W      = $clog2(WIN_ENTRIES);

    // square of a magnitude up to 2^15, and the window sum of those
    localparam int SQ_W   = 2 * LEVEL_W - 1;
    localparam int SUM_W  = SQ_W + POS_W;
    localparam int MEAN_W = SUM_W - POS_W;
    // shared subtractor: root remainder plus two radicand bits
    localparam int ALU_W  = LEVEL_W + 3;
    localparam int RAD_W  = 2 * LEVEL_W;
    localparam int STEP_W = $clog2(LEVEL_W);

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]          now_ms;
    } meter_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak_level;
        logic [LEVEL_W-1:0] rms_level;
        logic               stats_refreshed;
    } meter_out_t;

endpackage

// ===== rtl/wprm_arith.sv =====
// iterative floor square root of the mean of squares
// one shared compare-subtract unit, one root bit per cycle; uses wprm_pkg
module wprm_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wprm_pkg::MEAN_W-1:0]   mean_sq,
    output logic                          done,
    output logic [wprm_pkg::LEVEL_W-1:0]  root
);
    import wprm_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_SQRT = 3'b010,
        A_DONE = 3'b100
    } arith_state_t;

    arith_state_t       phase_reg, phase_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [ALU_W-1:0]   rem_reg, rem_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [LEVEL_W-1:0] root_reg, root_next;

    logic [ALU_W-1:0]   opa, opb;
    logic [ALU_W:0]     diff;
    logic               fits;

    // the one subtractor: remainder with two radicand bits against root with 01
    always_comb
    begin
        opa  = {rem_reg[ALU_W-3:0], rad_reg[RAD_W-1 -: 2]};
        opb  = {{(ALU_W-LEVEL_W-2){1'b0}}, root_reg, 2'b01};
        diff = {1'b0, opa} - {1'b0, opb};
        fits = !diff[ALU_W];
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        case (phase_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    // mean of squares is at most 2^30, so it fits the radicand
                    rad_next   = RAD_W'(mean_sq);
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    phase_next = A_SQRT;
                end
            end
            A_SQRT:
            begin
                rem_next  = fits ? diff[ALU_W-1:0] : opa;
                root_next = {root_reg[LEVEL_W-2:0], fits};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LEVEL_W - 1))
                begin
                    phase_next = A_DONE;
                end
            end
            A_DONE:
            begin
                phase_next = A_IDLE;
            end
            default:
            begin
                phase_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= A_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = (phase_reg == A_DONE);
    assign root = root_reg;

endmodule

// ===== rtl/windowed_peak_rms_meter.sv =====
// top level of the windowed peak and rms level meter
// holds the sample window memory and the scan sequencer; uses wprm_pkg, wprm_arith
//
// usage:
//   sample channel (sample_valid / sample_stall / sample_item) carries one item:
//   channel, signed Q1.15 sample and a millisecond timestamp. level channel
//   (level_valid / level_stall / level_item) returns one item per input item:
//   the channel's stored peak and rms and a flag set when this item refreshed
//   them. cfg_write with cfg_data sets the refresh period in ms.
//   the block holds one item at a time and keeps sample_stall high meanwhile.
//   without a refresh an item passes the write and result states (only the
//   result state for an ignored channel); the next item can go in as soon as
//   level_valid rises. a refresh walks the window through the one read port,
//   one entry a cycle, shifts the sum down to the mean and takes the root one
//   bit a cycle, passing the write, scan, drain, calc and result states.
//   a channel index past the last channel changes nothing and reports zeros.
//   reset clears the stored levels and refresh time, sets the period to 50 ms
//   and marks every window empty by write position and wrap flag; no clearing.
//   the result sits in an output register; while level_stall is high it
//   holds, and the next item may be accepted but waits to deliver its result.
module windowed_peak_rms_meter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  wprm_pkg::meter_in_t    sample_item,
    output logic                   level_valid,
    input  logic                   level_stall,
    output wprm_pkg::meter_out_t   level_item,
    input  logic                   cfg_write,
    input  logic [wprm_pkg::PERIOD_W-1:0] cfg_data
);
    import wprm_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRITE  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_CALC   = 6'b010000,
        S_RESULT = 6'b100000
    } meter_state_t;

    meter_state_t        state_reg, state_next;
    meter_in_t           item_reg;
    logic                ok_reg;
    logic                refresh_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   last_reg;

    logic [POS_W-1:0]    wpos_reg    [CHANNELS];
    logic                wrapped_reg [CHANNELS];
    logic [LEVEL_W-1:0]  peak_store_reg [CHANNELS];
    logic [LEVEL_W-1:0]  rms_store_reg  [CHANNELS];

    logic [SAMPLE_W-1:0] win_mem [WIN_ENTRIES];
    logic [SAMPLE_W-1:0] rd_data_reg;

    logic [POS_W-1:0]    cnt_reg;
    logic                s1_v_reg, s1_live_reg;
    logic                s2_v_reg;
    logic [LEVEL_W-1:0]  mag_reg;
    logic                s3_v_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [LEVEL_W-1:0]  peak_acc_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                out_valid_reg;
    meter_out_t          out_item_reg;

    logic                accept;
    logic                ch_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [POS_W-1:0]    wpos_cur;
    logic                wrapped_cur;
    logic                last_pos;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic [TIME_W-1:0]   elapsed;
    logic                due;
    logic                scan_end;
    logic                pipe_empty;
    logic                out_free;
    logic [LEVEL_W-1:0]  mag_raw;
    logic [2*LEVEL_W-1:0] prod;
    logic                arith_start;
    logic                arith_done;
    logic [LEVEL_W-1:0]  arith_root;

    assign accept = sample_valid && !sample_stall;
    assign ch_ok  = CH_CNT_W'(sample_item.channel) < CH_CNT_W'(CHANNELS);
    assign ch_idx = item_reg.channel[CH_IDX_W-1:0];

    assign wpos_cur    = wpos_reg[ch_idx];
    assign wrapped_cur = wrapped_reg[ch_idx];
    assign last_pos    = (wpos_cur == POS_W'(WINDOW_DEPTH - 1));

    assign base     = ADDR_W'(ch_idx) * ADDR_W'(WINDOW_DEPTH);
    assign mem_we   = (state_reg == S_WRITE);
    assign mem_addr = base + ADDR_W'(mem_we ? wpos_cur : cnt_reg);

    // unsigned wrapping difference against the shared refresh time
    assign elapsed = item_reg.now_ms - last_reg;
    assign due     = elapsed >= TIME_W'(period_reg);

    assign scan_end    = (cnt_reg == POS_W'(WINDOW_DEPTH - 1));
    assign pipe_empty  = !s1_v_reg && !s2_v_reg && !s3_v_reg;
    assign out_free    = !out_valid_reg || !level_stall;
    assign arith_start = (state_reg == S_DRAIN) && pipe_empty;

    // most negative sample negates to 0x8000, which is its magnitude
    assign mag_raw = rd_data_reg[SAMPLE_W-1] ? (LEVEL_W'(0) - rd_data_reg) : rd_data_reg;
    assign prod    = mag_reg * mag_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ch_ok ? S_WRITE : S_RESULT;
                end
            end
            S_WRITE:
            begin
                state_next = due ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (arith_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ok_reg        <= 1'b0;
            refresh_reg   <= 1'b0;
            period_reg    <= PERIOD_RESET;
            last_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wpos_reg[i]       <= '0;
                wrapped_reg[i]    <= 1'b0;
                peak_store_reg[i] <= '0;
                rms_store_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= (state_reg == S_SCAN);
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;

            if (cfg_write)
            begin
                period_reg <= cfg_data;
            end

            if (accept)
            begin
                ok_reg      <= ch_ok;
                refresh_reg <= 1'b0;
            end

            if (state_reg == S_WRITE)
            begin
                wpos_reg[ch_idx] <= last_pos ? '0 : wpos_cur + 1'b1;
                if (last_pos)
                begin
                    wrapped_reg[ch_idx] <= 1'b1;
                end
                if (due)
                begin
                    last_reg    <= item_reg.now_ms;
                    refresh_reg <= 1'b1;
                end
            end

            if ((state_reg == S_CALC) && arith_done)
            begin
                peak_store_reg[ch_idx] <= peak_acc_reg;
                rms_store_reg[ch_idx]  <= arith_root;
            end

            if ((state_reg == S_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!level_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // window memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_addr] <= $unsigned(item_reg.sample);
        end
        rd_data_reg <= win_mem[mem_addr];
    end

    // input item capture, scan datapath (read, magnitude, square and peak, accumulate) and output item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample_item;
        end

        if (state_reg == S_WRITE)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end

        // entries at or past the write position before the first wrap were never written
        s1_live_reg <= wrapped_cur || (cnt_reg < wpos_cur);
        mag_reg     <= s1_live_reg ? mag_raw : '0;
        sq_reg      <= prod[SQ_W-1:0];

        if (state_reg == S_WRITE)
        begin
            peak_acc_reg <= '0;
        end
        else if (s2_v_reg && (mag_reg > peak_acc_reg))
        begin
            peak_acc_reg <= mag_reg;
        end

        if (state_reg == S_WRITE)
        begin
            sum_reg <= '0;
        end
        else if (s3_v_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end

        if ((state_reg == S_RESULT) && out_free)
        begin
            out_item_reg.peak_level      <= ok_reg ? peak_store_reg[ch_idx] : '0;
            out_item_reg.rms_level       <= ok_reg ? rms_store_reg[ch_idx] : '0;
            out_item_reg.stats_refreshed <= ok_reg && refresh_reg;
        end
    end

    // mean of squares is the window sum shifted down by the depth bits
    wprm_arith u_arith (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (arith_start),
        .mean_sq (sum_reg[SUM_W-1:POS_W]),
        .done    (arith_done),
        .root    (arith_root)
    );

    assign sample_stall = (state_reg != S_IDLE);
    assign level_valid  = out_valid_reg;
    assign level_item   = out_item_reg;

    `ASSERT_PROP(a_calc_pipe_empty, clk, rst_n, (state_reg == S_CALC) |-> pipe_empty, "scan pipeline busy during root calculation")
    `ASSERT_PROP(a_done_in_calc, clk, rst_n, arith_done |-> (state_reg == S_CALC), "root unit finished outside calc state")
    `ASSERT_PROP(a_peak_range, clk, rst_n, (state_reg == S_CALC) |-> (peak_acc_reg <= MAG_MAX), "peak above full scale magnitude")
    `ASSERT_PROP(a_bad_channel_zero, clk, rst_n, ((state_reg == S_RESULT) && out_free && !ok_reg) |=> ((level_item.peak_level == '0) && (level_item.rms_level == '0) && !level_item.stats_refreshed), "out of range channel did not report zeros")

endmodule
